// ===== rtl/core/yps_pkg.sv =====
package yps_pkg;

	// item kinds on the input channel
	typedef enum logic [0:0] {
		KIND_CHAR = 1'b0,
		KIND_END  = 1'b1
	} item_kind_t;

	// result codes
	typedef enum logic [2:0] {
		SK_NULL   = 3'd0,
		SK_BOOL   = 3'd1,
		SK_INT    = 3'd2,
		SK_FLOAT  = 3'd3,
		SK_STRING = 3'd4
	} scalar_kind_t;

	// number / float recognizer positions
	typedef enum logic [4:0] {
		PS_START = 5'd0,
		PS_SIGN  = 5'd1,
		PS_ZERO  = 5'd2,
		PS_DEC   = 5'd3,
		PS_LZDIG = 5'd4,
		PS_HEXP  = 5'd5,
		PS_HEX   = 5'd6,
		PS_OCTP  = 5'd7,
		PS_OCT   = 5'd8,
		PS_DOT0  = 5'd9,
		PS_FRAC  = 5'd10,
		PS_EXP   = 5'd11,
		PS_EXPS  = 5'd12,
		PS_EXPD  = 5'd13,
		PS_I1    = 5'd14,
		PS_I2    = 5'd15,
		PS_N1    = 5'd16,
		PS_N2    = 5'd17,
		PS_SPEC  = 5'd18,
		PS_DEAD  = 5'd19
	} parse_state_t;

	localparam int WORD_COUNT = 10;
	localparam int NULL_WORDS = 4;
	localparam int POS_COUNT  = 8;
	localparam int COUNT_W    = 3;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

	// literal words: ~, null, Null, NULL, true, True, TRUE, false, False, FALSE
	localparam logic [COUNT_W-1:0] WORD_LEN [WORD_COUNT] = '{
		3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5
	};

	localparam logic [7:0] WORD_TEXT [WORD_COUNT][POS_COUNT] = '{
		'{"~", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"N", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"N", "U", "L", "L", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"T", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"T", "R", "U", "E", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
		'{"F", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
		'{"F", "A", "L", "S", "E", 8'h00, 8'h00, 8'h00}
	};

	// scanner state carried from character to character
	typedef struct packed {
		parse_state_t            parse;
		logic [WORD_COUNT-1:0]   cand;
		logic [COUNT_W-1:0]      count;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		parse: PS_START,
		cand:  {WORD_COUNT{1'b1}},
		count: '0
	};

endpackage

// ===== rtl/core/yps_in_if.sv =====
interface yps_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;
	logic       quoted;

	modport source (output valid, output kind, output char_code, output quoted, input ready);
	modport sink   (input valid, input kind, input char_code, input quoted, output ready);
endinterface

// ===== rtl/core/yps_out_if.sv =====
interface yps_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] scalar_kind;

	modport source (output valid, output scalar_kind, input ready);
	modport sink   (input valid, input scalar_kind, output ready);
endinterface

// ===== rtl/core/yps_step.sv =====
module yps_step (
	input  yps_pkg::scan_state_t cur,
	input  logic [7:0]           char_code,
	output yps_pkg::scan_state_t nxt
);

	logic [7:0] lc;
	logic       is_dig;
	logic       is_hex;
	logic       is_oct;
	logic       is_sign;
	yps_pkg::parse_state_t ps_nxt;

	// character classes
	always_comb begin
		lc      = (char_code >= "A" && char_code <= "Z") ? char_code + 8'd32 : char_code;
		is_dig  = char_code >= "0" && char_code <= "9";
		is_hex  = is_dig || (lc >= "a" && lc <= "f");
		is_oct  = char_code >= "0" && char_code <= "7";
		is_sign = char_code == "+" || char_code == "-";
	end

	// recognizer transition
	always_comb begin
		ps_nxt = yps_pkg::PS_DEAD;
		case (cur.parse)
			yps_pkg::PS_START, yps_pkg::PS_SIGN: begin
				if (cur.parse == yps_pkg::PS_START && is_sign) ps_nxt = yps_pkg::PS_SIGN;
				else if (char_code == "0") ps_nxt = yps_pkg::PS_ZERO;
				else if (is_dig) ps_nxt = yps_pkg::PS_DEC;
				else if (char_code == ".") ps_nxt = yps_pkg::PS_DOT0;
			end
			yps_pkg::PS_ZERO: begin
				if (lc == "x") ps_nxt = yps_pkg::PS_HEXP;
				else if (lc == "o") ps_nxt = yps_pkg::PS_OCTP;
				else if (is_dig) ps_nxt = yps_pkg::PS_LZDIG;
				else if (char_code == ".") ps_nxt = yps_pkg::PS_FRAC;
				else if (lc == "e") ps_nxt = yps_pkg::PS_EXP;
			end
			yps_pkg::PS_DEC, yps_pkg::PS_LZDIG: begin
				if (is_dig) ps_nxt = cur.parse;
				else if (char_code == ".") ps_nxt = yps_pkg::PS_FRAC;
				else if (lc == "e") ps_nxt = yps_pkg::PS_EXP;
			end
			yps_pkg::PS_HEXP, yps_pkg::PS_HEX: begin
				if (is_hex) ps_nxt = yps_pkg::PS_HEX;
			end
			yps_pkg::PS_OCTP, yps_pkg::PS_OCT: begin
				if (is_oct) ps_nxt = yps_pkg::PS_OCT;
			end
			yps_pkg::PS_DOT0: begin
				if (is_dig) ps_nxt = yps_pkg::PS_FRAC;
				else if (lc == "i") ps_nxt = yps_pkg::PS_I1;
				else if (lc == "n") ps_nxt = yps_pkg::PS_N1;
			end
			yps_pkg::PS_FRAC: begin
				if (is_dig) ps_nxt = yps_pkg::PS_FRAC;
				else if (lc == "e") ps_nxt = yps_pkg::PS_EXP;
			end
			yps_pkg::PS_EXP: begin
				if (is_sign) ps_nxt = yps_pkg::PS_EXPS;
				else if (is_dig) ps_nxt = yps_pkg::PS_EXPD;
			end
			yps_pkg::PS_EXPS, yps_pkg::PS_EXPD: begin
				if (is_dig) ps_nxt = yps_pkg::PS_EXPD;
			end
			yps_pkg::PS_I1: begin
				if (lc == "n") ps_nxt = yps_pkg::PS_I2;
			end
			yps_pkg::PS_I2: begin
				if (lc == "f") ps_nxt = yps_pkg::PS_SPEC;
			end
			yps_pkg::PS_N1: begin
				if (lc == "a") ps_nxt = yps_pkg::PS_N2;
			end
			yps_pkg::PS_N2: begin
				if (lc == "n") ps_nxt = yps_pkg::PS_SPEC;
			end
			default: ps_nxt = yps_pkg::PS_DEAD;
		endcase
	end

	// literal word match at the current position, saturating count
	always_comb begin
		nxt.parse = ps_nxt;
		for (int k = 0; k < yps_pkg::WORD_COUNT; k++) begin
			nxt.cand[k] = cur.cand[k] && (cur.count < yps_pkg::WORD_LEN[k]) &&
				(yps_pkg::WORD_TEXT[k][cur.count] == char_code);
		end
		nxt.count = (cur.count == yps_pkg::COUNT_MAX) ? cur.count : cur.count + 3'd1;
	end

endmodule

// ===== rtl/core/yps_classify.sv =====
module yps_classify (
	input  yps_pkg::scan_state_t  cur,
	input  logic                  quoted,
	output yps_pkg::scalar_kind_t scalar_kind
);

	logic null_hit;
	logic bool_hit;

	// a literal word matches when it is still a candidate and fully seen
	always_comb begin
		null_hit = 1'b0;
		bool_hit = 1'b0;
		for (int k = 0; k < yps_pkg::WORD_COUNT; k++) begin
			if (cur.cand[k] && yps_pkg::WORD_LEN[k] == cur.count) begin
				if (k < yps_pkg::NULL_WORDS) null_hit = 1'b1;
				else bool_hit = 1'b1;
			end
		end
	end

	// final resolution
	always_comb begin
		if (quoted) scalar_kind = yps_pkg::SK_STRING;
		else if (null_hit) scalar_kind = yps_pkg::SK_NULL;
		else if (bool_hit) scalar_kind = yps_pkg::SK_BOOL;
		else if (cur.count == '0) scalar_kind = yps_pkg::SK_NULL;
		else begin
			case (cur.parse)
				yps_pkg::PS_ZERO, yps_pkg::PS_DEC,
				yps_pkg::PS_HEX, yps_pkg::PS_OCT: scalar_kind = yps_pkg::SK_INT;
				yps_pkg::PS_FRAC, yps_pkg::PS_EXPD,
				yps_pkg::PS_SPEC: scalar_kind = yps_pkg::SK_FLOAT;
				default: scalar_kind = yps_pkg::SK_STRING;
			endcase
		end
	end

endmodule

// ===== rtl/core/yaml_plain_scalar_classifier_top.sv =====
// an end item is held in the input register, then its result is loaded into the result register
// throughput: one item per cycle while no end item is stalled, set by the scanner update
// between the input register and the result register
// a full, unread result register holds back only a following end item
// reset (arst_n low) empties both registers and returns the scanner to start of scalar
module yaml_plain_scalar_classifier_top (
	input  logic      clk,
	input  logic      arst_n,
	yps_in_if.sink    item,
	yps_out_if.source result
);

	logic                  valid_s1;
	logic                  kind_s1;
	logic [7:0]            char_s1;
	logic                  quoted_s1;
	logic                  end_s1;
	logic                  stall;
	logic                  take_s1;
	yps_pkg::scan_state_t  state_q;
	yps_pkg::scan_state_t  state_nxt;
	yps_pkg::scalar_kind_t kind_res;
	logic                  out_valid_q;
	yps_pkg::scalar_kind_t out_kind_q;

	// flow control: only an end item needs room in the result register
	assign end_s1     = kind_s1 == yps_pkg::KIND_END;
	assign stall      = valid_s1 && end_s1 && out_valid_q && !result.ready;
	assign take_s1    = valid_s1 && !stall;
	assign item.ready = !valid_s1 || !stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1   <= item.kind;
			char_s1   <= item.char_code;
			quoted_s1 <= item.quoted;
		end
	end

	yps_step u_step (
		.cur       (state_q),
		.char_code (char_s1),
		.nxt       (state_nxt)
	);

	yps_classify u_classify (
		.cur         (state_q),
		.quoted      (quoted_s1),
		.scalar_kind (kind_res)
	);

	// scanner state: advance on a character, restart after an end item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= yps_pkg::SCAN_RESET;
		end else if (take_s1) begin
			state_q <= end_s1 ? yps_pkg::SCAN_RESET : state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && end_s1) begin
			out_kind_q <= kind_res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.scalar_kind = out_kind_q;

	// scanner restarts after every end item
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && end_s1) |=> (state_q == yps_pkg::SCAN_RESET))
		else $error("scanner not restarted after end transfer");

	// a character always moves the count forward or holds it at saturation
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && !end_s1) |=> (state_q.count != '0 &&
			state_q.count >= $past(state_q.count)))
		else $error("character count did not advance");

	// a new result only ever follows an end item
	a_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(take_s1 && end_s1))
		else $error("result without end item");

	// quoted scalars resolve to string
	a_quoted: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && end_s1 && quoted_s1) |=> (result.scalar_kind == yps_pkg::SK_STRING))
		else $error("quoted scalar not classified as string");

endmodule
